>>> rtl/pcic_pkg.sv
// Shared constants for the prime counting block.
package pcic_pkg;

  localparam int FIELD_W        = 32;  // width of the range ports
  localparam int COUNT_W        = 31;  // width of the result count
  localparam int MAX_EFF_BITS   = 32;  // values are never read wider than this
  localparam int VALUE_BITS_DEF = 32;  // default signed value width
  localparam int MIN_PRIME      = 2;   // smallest prime, first trial divisor

endpackage

>>> rtl/prime_count_in_range_top.sv
// Prime counting over an inclusive range by trial division on a shared divider.
//
//   channel  | ports                                  | handshake
//   ---------+----------------------------------------+-------------------------
//   request  | in_range_first, in_range_last          | start high, busy low
//   result   | out_prime_count                        | out_valid, one cycle
//
// Each candidate from max(first, 2) to last is divided by d = 2, 3, ... until
// d > v/d (prime) or a zero remainder (composite). Each trial is one run of the
// bit-serial divider at width VB = min(VALUE_BITS, 32) - 1, and the next trial
// is launched only after the divider reports done.
// Synchronous active-low reset returns to idle; busy stays high through the
// result cycle. The receiver cannot stall: out_valid lasts one cycle.
module prime_count_in_range_top
  import pcic_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [FIELD_W-1:0] in_range_first,
  input  logic [FIELD_W-1:0] in_range_last,
  output logic               out_valid,
  output logic [COUNT_W-1:0] out_prime_count
);

  localparam int EW = (VALUE_BITS < MAX_EFF_BITS) ? VALUE_BITS : MAX_EFF_BITS;
  localparam int UW = EW - 1;  // candidates are positive, sign bit dropped

  localparam logic signed [EW-1:0] TWO_S = EW'(MIN_PRIME);
  localparam logic [UW-1:0]        TWO_U = UW'(MIN_PRIME);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LAUNCH = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [UW-1:0]      cand_r,  cand_nxt;
  logic [UW-1:0]      last_r,  last_nxt;
  logic [UW-1:0]      d_r,     d_nxt;
  logic [COUNT_W-1:0] cnt_r,   cnt_nxt;

  logic signed [EW-1:0] first_s;
  logic signed [EW-1:0] last_s;
  logic                 div_start;
  logic                 div_done;
  logic [UW-1:0]        div_quo;
  logic [UW-1:0]        div_rem;

  assign first_s = in_range_first[EW-1:0];
  assign last_s  = in_range_last[EW-1:0];

  pcic_div #(
    .W(UW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .div_start(div_start),
    .div_num  (cand_r),
    .div_den  (d_r),
    .div_done (div_done),
    .div_quo  (div_quo),
    .div_rem  (div_rem)
  );

  assign div_start = (state_r == ST_LAUNCH);

  always_comb begin
    state_nxt = state_r;
    cand_nxt  = cand_r;
    last_nxt  = last_r;
    d_nxt     = d_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cnt_nxt  = '0;
          d_nxt    = TWO_U;
          last_nxt = last_s[UW-1:0];
          cand_nxt = (first_s < TWO_S) ? TWO_U : first_s[UW-1:0];
          // empty range or nothing at or above two
          if ((first_s > last_s) || (last_s < TWO_S)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_LAUNCH;
          end
        end
      end
      ST_LAUNCH: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          // d > v/d means no divisor up to the square root
          if ((div_quo < d_r) || (div_rem == '0)) begin
            if (div_quo < d_r) begin
              cnt_nxt = cnt_r + COUNT_W'(1);
            end
            d_nxt = TWO_U;
            if (cand_r == last_r) begin
              state_nxt = ST_DONE;
            end else begin
              cand_nxt  = cand_r + UW'(1);
              state_nxt = ST_LAUNCH;
            end
          end else begin
            d_nxt     = d_r + UW'(1);
            state_nxt = ST_LAUNCH;
          end
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    cand_r <= cand_nxt;
    last_r <= last_nxt;
    d_r    <= d_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_DONE);
  assign out_prime_count = cnt_r;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after request");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe longer than one cycle");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_WAIT))
    else $error("divider finished outside wait state");

  a_prime_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT && div_done && div_quo < d_r)
      |=> (cnt_r == $past(cnt_r) + COUNT_W'(1)))
    else $error("prime not counted");
`endif

endmodule

>>> rtl/pcic_div.sv
// Restoring divider, one quotient bit per cycle, shared by all trial divisions.
module pcic_div #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         div_start,
  input  logic [W-1:0] div_num,
  input  logic [W-1:0] div_den,
  output logic         div_done,
  output logic [W-1:0] div_quo,
  output logic [W-1:0] div_rem
);

  localparam int CW = $clog2(W);

  logic          run_r,  run_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r,  cnt_nxt;
  logic [W-1:0]  quo_r,  quo_nxt;
  logic [W-1:0]  rem_r,  rem_nxt;
  logic [W-1:0]  den_r,  den_nxt;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (div_start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      quo_nxt = div_num;
      rem_nxt = '0;
      den_nxt = div_den;
    end else if (run_r) begin
      // diff[W] set means the shifted remainder is below the divisor
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign div_done = done_r;
  assign div_quo  = quo_r;
  assign div_rem  = rem_r;

endmodule

>>> tb/prime_count_in_range_top_tb.sv
// Testbench for prime_count_in_range_top: directed and random range requests, scoreboard.
`timescale 1ns / 100ps

class prime_count_board;
  int          vbits;
  int unsigned expected_counts[$];
  int unsigned mismatches;

  function new(int vbits_in);
    vbits = vbits_in;
  endfunction

  // field as the block reads it: low min(vbits, 32) bits, two's complement
  function longint field_value(logic [31:0] raw);
    int     eff;
    longint m;
    eff = (vbits < 32) ? vbits : 32;
    m = longint'(raw) & ((longint'(1) << eff) - 1);
    if (m[eff-1])
      m = m - (longint'(1) << eff);
    return m;
  endfunction

  function bit trial_prime(longint v);
    longint d;
    if (v < 2)
      return 1'b0;
    for (d = 2; d * d <= v; d++) begin
      if (v % d == 0)
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function int unsigned primes_in_range(longint first, longint last);
    int unsigned n;
    longint      v;
    n = 0;
    for (v = (first < 2) ? 2 : first; v <= last; v++) begin
      if (trial_prime(v))
        n++;
    end
    return n & 32'h7FFF_FFFF;
  endfunction

  function void note_request(logic [31:0] first, logic [31:0] last);
    expected_counts.push_back(primes_in_range(field_value(first), field_value(last)));
  endfunction

  function void check_count(logic [30:0] got);
    int unsigned want;
    if (expected_counts.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected count %0d with no request pending", got);
      return;
    end
    want = expected_counts.pop_front();
    if (got !== want[30:0]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("count mismatch: expected %0d, got %0d", want, got);
    end
  endfunction
endclass

module prime_count_in_range_top_tb;
  import pcic_pkg::*;

  localparam int VALUE_BITS = VALUE_BITS_DEF;
  localparam logic [31:0] INT_MIN = 32'h8000_0000;
  localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [FIELD_W-1:0] in_range_first;
  logic [FIELD_W-1:0] in_range_last;
  logic               out_valid;
  logic [COUNT_W-1:0] out_prime_count;

  prime_count_board board = new(VALUE_BITS);

  prime_count_in_range_top #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_range_first  (in_range_first),
    .in_range_last   (in_range_last),
    .out_valid       (out_valid),
    .out_prime_count (out_prime_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      board.check_count(out_prime_count);
  end

  // mostly short idle gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // holds the request until an edge with busy low takes it
  task automatic send_range(logic [31:0] first, logic [31:0] last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_range_first <= first;
    in_range_last  <= last;
    do @(posedge clk); while (busy);
    board.note_request(first, last);
  endtask

  task automatic send_random_range();
    int unsigned kind;
    logic [31:0] a;
    logic [31:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      // short window over small values
      a = 32'($urandom_range(0, 1500)) - 32'd50;
      b = a + 32'($urandom_range(0, 30));
    end else if (kind < 75) begin
      // deep negative start, few real candidates
      a = {1'b1, 31'($urandom())};
      b = 32'($urandom_range(0, 200)) - 32'd20;
    end else if (kind < 85) begin
      // empty range with arbitrary bounds
      a = $urandom();
      b = $urandom();
      if (a == b)
        b = b ^ 32'd1;
      if ($signed(a) < $signed(b)) begin
        a = a ^ b;
        b = a ^ b;
        a = a ^ b;
      end
    end else if (kind < 95) begin
      // single large value with a factor of 2 or 7, composite unless it is 7
      if ($urandom_range(0, 1))
        a = $urandom() & 32'h7FFF_FFFE;
      else
        a = 32'd7 * 32'($urandom_range(1, 306783378));
      if (a < 32'd4)
        a = 32'd4;
      b = a;
    end else begin
      // both bounds negative
      a = {1'b1, 31'($urandom())};
      b = {1'b1, 31'($urandom())};
      if ($signed(a) > $signed(b)) begin
        a = a ^ b;
        b = a ^ b;
        a = a ^ b;
      end
    end
    send_range(a, b);
  endtask

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_range_first <= '0;
    in_range_last  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_range(32'd2, 32'd2);
    send_range(32'd0, 32'd1);
    send_range(32'd1, 32'd2);
    send_range(32'd3, 32'd3);
    send_range(32'd4, 32'd4);
    send_range(32'd9, 32'd9);
    send_range(32'd25, 32'd25);
    send_range(32'd961, 32'd961);
    send_range(-32'sd5, 32'd30);
    send_range(32'd10, 32'd9);
    send_range(32'd100, 32'd97);
    send_range(32'd1, 32'd100);
    send_range(32'd48, 32'd60);
    send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_range(32'd0, 32'd0);
    send_range(INT_MIN, INT_MIN);
    send_range(INT_MIN, 32'd100);
    send_range(INT_MAX, INT_MIN);
    send_range(INT_MAX, 32'd100);
    send_range(INT_MAX, INT_MAX - 32'd1);
    send_range(INT_MAX - 32'd1, INT_MAX - 32'd1);
    send_range(32'd1000003, 32'd1000003);

    repeat (100) send_random_range();
    start <= 1'b0;

    while (board.expected_counts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (board.mismatches == 0 && board.expected_counts.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
rtl/pcic_pkg.sv
rtl/pcic_div.sv
rtl/prime_count_in_range_top.sv
tb/prime_count_in_range_top_tb.sv
